// ===== design/arp_cache_fifo_table_top_defines.svh =====
// assertion macros for the arp cache table
`ifndef ARP_CACHE_FIFO_TABLE_TOP_DEFINES_SVH
`define ARP_CACHE_FIFO_TABLE_TOP_DEFINES_SVH

// condition in this cycle implies property in the same cycle
`define ACF_ASSERT_SAME(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// condition in this cycle implies property in the next cycle
`define ACF_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== design/acf_pkg.sv =====
// shared types and constants of the arp cache table
package acf_pkg;

    localparam int IP_W  = 32;
    localparam int MAC_W = 48;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_LOOKUP = 1'b1
    } t_req_type;

    // search token walking down the row of cells
    typedef struct packed {
        logic             vld;
        logic [IP_W-1:0]  key;
        logic             hit;
        logic [MAC_W-1:0] mac;
    } t_search;

endpackage

// ===== design/arp_cache_fifo_table_top.sv =====
// top level of the arp cache table: row of slot cells, search pipeline, result register
//
//  channel  | dir | handshake              | payload
//  request  | in  | i_s_tvalid/o_s_tready  | tuser: req_type; tdata: ip_addr, mac_in
//  result   | out | o_m_tvalid/i_m_tready  | tuser: found; tdata: mac_out
//
// an insert waits until no lookup is still in the cell row
// a lookup walks the row one cell at a time, then enters the result register
// while the result register takes data, lookups follow each other every cycle
// a stalled result register freezes the whole search row
// reset (synchronous, active low) empties the table and drops searches in flight
`include "arp_cache_fifo_table_top_defines.svh"

module arp_cache_fifo_table_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [79:0] i_s_tdata,   // [31:0] ip_addr, [79:32] mac_in
    input  logic        i_s_tuser,   // [0] req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [47:0] mac_out
    output logic        o_m_tuser    // [0] found
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [acf_pkg::IP_W-1:0]  new_ip;
    logic [acf_pkg::MAC_W-1:0] new_mac;
    logic                      is_lookup;
    logic                      adv;
    logic                      acc;
    logic                      ins;
    logic                      full;
    logic [CW-1:0]             r_inflight;
    logic [CW-1:0]             n_inflight;
    logic                      r_out_valid;
    logic                      r_found;
    logic [acf_pkg::MAC_W-1:0] r_mac;

    logic [TABLE_DEPTH-1:0]    w_valid;
    logic [acf_pkg::IP_W-1:0]  w_ip  [TABLE_DEPTH];
    logic [acf_pkg::MAC_W-1:0] w_mac [TABLE_DEPTH];
    acf_pkg::t_search          w_tok [TABLE_DEPTH+1];

    assign new_ip    = i_s_tdata[31:0];
    assign new_mac   = i_s_tdata[79:32];
    assign is_lookup = (i_s_tuser == acf_pkg::REQ_LOOKUP);

    assign adv  = !r_out_valid || i_m_tready;
    assign full = w_valid[TABLE_DEPTH-1];

    // lookups need the row moving; inserts need the row empty of searches
    assign o_s_tready = is_lookup ? adv : (r_inflight == '0);
    assign acc        = i_s_tvalid && o_s_tready;
    assign ins        = acc && !is_lookup;

    always_comb begin
        w_tok[0].vld = acc && is_lookup;
        w_tok[0].key = new_ip;
        w_tok[0].hit = 1'b0;
        w_tok[0].mac = '0;
    end

    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        logic                      prev_valid;
        logic [acf_pkg::IP_W-1:0]  shift_ip;
        logic [acf_pkg::MAC_W-1:0] shift_mac;

        if (k == 0) begin : g_first
            assign prev_valid = 1'b1;
        end else begin : g_mid
            assign prev_valid = w_valid[k-1];
        end

        if (k == TABLE_DEPTH - 1) begin : g_last
            assign shift_ip  = new_ip;
            assign shift_mac = new_mac;
        end else begin : g_inner
            assign shift_ip  = w_ip[k+1];
            assign shift_mac = w_mac[k+1];
        end

        acf_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_adv        (adv),
            .i_ins        (ins),
            .i_full       (full),
            .i_prev_valid (prev_valid),
            .i_shift_ip   (shift_ip),
            .i_shift_mac  (shift_mac),
            .i_new_ip     (new_ip),
            .i_new_mac    (new_mac),
            .i_tok        (w_tok[k]),
            .o_valid      (w_valid[k]),
            .o_ip         (w_ip[k]),
            .o_mac        (w_mac[k]),
            .o_tok        (w_tok[k+1])
        );
    end

    always_comb begin
        n_inflight = r_inflight;
        if (acc && is_lookup) begin
            n_inflight = n_inflight + CW'(1);
        end
        if (adv && w_tok[TABLE_DEPTH].vld) begin
            n_inflight = n_inflight - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_inflight <= n_inflight;
            if (adv) begin
                r_out_valid <= w_tok[TABLE_DEPTH].vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_found <= w_tok[TABLE_DEPTH].hit;
            r_mac   <= w_tok[TABLE_DEPTH].mac;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_found;
    assign o_m_tdata  = r_mac;

    `ACF_ASSERT_SAME(a_ins_row_idle, ins, r_inflight == '0, "insert with searches in flight")
    `ACF_ASSERT_SAME(a_inflight_bound, 1'b1, r_inflight <= CW'(TABLE_DEPTH),
        "search count above row length")
    `ACF_ASSERT_SAME(a_miss_zero, o_m_tvalid && !o_m_tuser, o_m_tdata == '0,
        "miss result with nonzero mac")
    `ACF_ASSERT_NEXT(a_fill_grows, ins && !full,
        $countones(w_valid) == $past($countones(w_valid)) + 1, "insert did not fill a slot")

endmodule

// ===== design/acf_cell.sv =====
// one table slot: stores an address pair and compares a passing search token
module acf_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  logic                      i_ins,
    input  logic                      i_full,
    input  logic                      i_prev_valid,
    input  logic [acf_pkg::IP_W-1:0]  i_shift_ip,
    input  logic [acf_pkg::MAC_W-1:0] i_shift_mac,
    input  logic [acf_pkg::IP_W-1:0]  i_new_ip,
    input  logic [acf_pkg::MAC_W-1:0] i_new_mac,
    input  acf_pkg::t_search          i_tok,
    output logic                      o_valid,
    output logic [acf_pkg::IP_W-1:0]  o_ip,
    output logic [acf_pkg::MAC_W-1:0] o_mac,
    output acf_pkg::t_search          o_tok
);

    logic                      r_valid;
    logic [acf_pkg::IP_W-1:0]  r_ip;
    logic [acf_pkg::MAC_W-1:0] r_mac;
    acf_pkg::t_search          r_tok;
    acf_pkg::t_search          n_tok;
    logic                      load_new;
    logic                      load_shift;
    logic                      match;

    // first free slot takes the new pair; a full row shifts toward slot zero
    assign load_new   = i_ins && !i_full && i_prev_valid && !r_valid;
    assign load_shift = i_ins && i_full;
    assign match      = r_valid && (r_ip == i_tok.key);

    always_comb begin
        n_tok     = i_tok;
        n_tok.hit = i_tok.hit || match;
        if (!i_tok.hit && match) begin
            n_tok.mac = r_mac;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load_new) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_new) begin
            r_ip  <= i_new_ip;
            r_mac <= i_new_mac;
        end else if (load_shift) begin
            r_ip  <= i_shift_ip;
            r_mac <= i_shift_mac;
        end
    end

    // only the valid bit of the token is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else if (i_adv) begin
            r_tok.vld <= n_tok.vld;
        end
        if (i_adv) begin
            r_tok.key <= n_tok.key;
            r_tok.hit <= n_tok.hit;
            r_tok.mac <= n_tok.mac;
        end
    end

    assign o_valid = r_valid;
    assign o_ip    = r_ip;
    assign o_mac   = r_mac;
    assign o_tok   = r_tok;

endmodule
